/* design/ste_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int POS_W      = 12;
   localparam int CODE_W     = 16;
   localparam int COLOR_W    = 6;

   // register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_FLIP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd2;

   localparam logic [CSR_DATA_W-1:0] SCREEN_WIDTH_RST  = 10'd320;
   localparam logic [CSR_DATA_W-1:0] SCREEN_HEIGHT_RST = 10'd224;

   localparam logic [POS_W-1:0] X_OFFSET = 12'd32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_EMIT
   } ste_state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic step;
   } ste_cmd_type;

   typedef struct packed {
      logic skip;
      logic last;
   } ste_status_type;

endpackage

`default_nettype wire

/* design/ste_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ste_ctrl
   import ste_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire ste_status_type status,
   output ste_cmd_type         cmd
);

   ste_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = status.skip ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready && status.last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SETUP: begin
            cmd.setup = !status.skip;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            cmd.step   = rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/ste_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ste_datapath
   import ste_pkg::*;
#(
   parameter int TILE_PIXELS    = 16,
   parameter int MAX_TILES_SIDE = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire ste_cmd_type           cmd,
   output ste_status_type             status,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int DIM_W  = $clog2(MAX_TILES_SIDE + 1);
   localparam int AREA_W = $clog2(MAX_TILES_SIDE * MAX_TILES_SIDE + 1);
   localparam int KOFF_W = $clog2(15 * MAX_TILES_SIDE + 1);
   localparam int SPAN_W = $clog2(MAX_TILES_SIDE * TILE_PIXELS + 1);
   localparam int COLX_W = $clog2(15 * TILE_PIXELS + 1);

   function automatic logic [DIM_W-1:0] tile_count(input logic [3:0] nib);
      logic [4:0] n;
      n = {1'b0, nib} + 5'd1;
      if (n > 5'(MAX_TILES_SIDE)) n = 5'(MAX_TILES_SIDE);
      return DIM_W'(n);
   endfunction

   // control registers
   logic                  flip_ff, flip_in;
   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;

   always_comb begin
      flip_in   = flip_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCREEN_FLIP:   flip_in   = csr_wdata[0];
            CSR_SCREEN_WIDTH:  width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: height_in = csr_wdata;
            default:           flip_in   = flip_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff   <= 1'b0;
         width_ff  <= SCREEN_WIDTH_RST;
         height_ff <= SCREEN_HEIGHT_RST;
      end else begin
         flip_ff   <= flip_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // input beat fields
   logic [15:0] size_word;
   logic [15:0] code_word;
   logic [9:0]  x_raw, y_raw;
   logic [5:0]  color_raw;
   logic [3:0]  col_raw;
   logic [DIM_W-1:0] dimx_in, dimy_in;

   assign size_word = req_tdata[15:0];
   assign code_word = req_tdata[31:16];
   assign x_raw     = req_tdata[41:32];
   assign y_raw     = req_tdata[57:48];
   assign color_raw = req_tdata[69:64];
   assign col_raw   = req_tdata[83:80];
   assign dimx_in   = tile_count(size_word[3:0]);
   assign dimy_in   = tile_count(size_word[7:4]);

   // captured sprite and the products taken from it
   logic              show_ff;
   logic              hibit_ff, flipx_ff;
   logic [14:0]       code_ff;
   logic [9:0]        x_ff, y_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [3:0]        col_ff;
   logic [DIM_W-1:0]  dimx_ff, dimy_ff;
   logic [AREA_W-1:0] area_ff;
   logic [KOFF_W-1:0] koff_ff;
   logic [SPAN_W-1:0] xspan_ff, yspan_ff;
   logic [COLX_W-1:0] colx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         show_ff  <= req_tuser;
         hibit_ff <= size_word[8];
         flipx_ff <= size_word[12];
         code_ff  <= code_word[14:0];
         x_ff     <= x_raw;
         y_ff     <= y_raw;
         color_ff <= color_raw;
         col_ff   <= col_raw;
         dimx_ff  <= dimx_in;
         dimy_ff  <= dimy_in;
         area_ff  <= AREA_W'(int'(dimx_in) * int'(dimy_in));
         koff_ff  <= KOFF_W'(int'(col_raw) * int'(dimy_in));
         xspan_ff <= SPAN_W'(int'(dimx_in) * TILE_PIXELS);
         yspan_ff <= SPAN_W'(int'(dimy_in) * TILE_PIXELS);
         colx_ff  <= COLX_W'(int'(col_raw) * TILE_PIXELS);
      end
   end

   // first tile of the column
   logic [14:0]       code_sum;
   logic [CODE_W-1:0] base_code, first_code;
   logic [POS_W-1:0]  sx_ext, sy_ext, sx, sy, first_px;

   always_comb begin
      code_sum   = code_ff + (flip_ff ? (15'(area_ff) - 15'd1) : 15'd0);
      base_code  = {hibit_ff, code_sum};
      first_code = flip_ff ? (base_code - CODE_W'(koff_ff))
                           : (base_code + CODE_W'(koff_ff));
      sx_ext = {{(POS_W-10){x_ff[9]}}, x_ff};
      sy_ext = {{(POS_W-10){y_ff[9]}}, y_ff};
      if (flip_ff) begin
         sx = POS_W'(width_ff) - sx_ext - POS_W'(xspan_ff) - X_OFFSET;
         sy = POS_W'(height_ff) - sy_ext - POS_W'(yspan_ff);
      end else begin
         sx = sx_ext + X_OFFSET;
         sy = sy_ext;
      end
      first_px = sx + POS_W'(colx_ff);
   end

   assign status.skip = !show_ff || ({1'b0, col_ff} >= 5'(dimx_ff));

   // running tile registers
   logic [CODE_W-1:0] tcode_ff, tcode_in;
   logic [POS_W-1:0]  px_ff, px_in;
   logic [POS_W-1:0]  py_ff, py_in;
   logic [DIM_W-1:0]  row_ff, row_in;

   always_comb begin
      tcode_in = tcode_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      row_in   = row_ff;
      if (cmd.setup) begin
         tcode_in = first_code;
         px_in    = first_px;
         py_in    = sy;
         row_in   = '0;
      end else if (cmd.step) begin
         tcode_in = flip_ff ? (tcode_ff - CODE_W'(1)) : (tcode_ff + CODE_W'(1));
         py_in    = py_ff + POS_W'(TILE_PIXELS);
         row_in   = row_ff + DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      tcode_ff <= tcode_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      row_ff   <= row_in;
   end

   assign status.last = (row_ff == (dimy_ff - DIM_W'(1)));
   assign rsp_tlast   = status.last;
   assign rsp_tdata   = {py_ff, px_ff, flip_ff, flipx_ff ^ flip_ff, color_ff, tcode_ff};

endmodule

`default_nettype wire

/* design/sprite_tile_expander.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          payload
// req_      in         tvalid / tready    tdata: sprite entry and column, tuser: display bit
// rsp_      out        tvalid / tready    tdata: tile command, tlast: last tile of column
// csr_      in         wr_en              index, wdata: screen flip, width, height
//
// a shown sprite: the beat is captured while idle, the first tile formed in setup, then h
// tiles (h = tile rows, 1 to 16) from the datapath row counter, one per cycle while
// rsp_tready is high; a hidden sprite or a column outside the sprite gives nothing
// reset is synchronous: flip 0, width 320, height 224, controller idle
// rsp_tready low holds the current tile; req_tready is high only while idle

module sprite_tile_expander
   import ste_pkg::*;
#(
   parameter int TILE_PIXELS    = 16,
   parameter int MAX_TILES_SIDE = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // size_word[15:0], code_word[31:16], x_word[47:32], y_word[63:48],
   // color_word[79:64], column_index[83:80], zero[87:84]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // show_sprite[0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tile_code[15:0], palette_color[21:16], mirror_x[22], mirror_y[23],
   // pos_x[35:24], pos_y[47:36]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ste_cmd_type    cmd;
   ste_status_type status;

   ste_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ste_datapath #(
      .TILE_PIXELS    (TILE_PIXELS),
      .MAX_TILES_SIDE (MAX_TILES_SIDE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_setup_gap: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!rsp_tvalid && !req_tready))
      else $error("tile beat or new sprite right after capture");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("sprite accepted while tiles pending");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("column did not end after last tile");

   a_column_x: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && (rsp_tdata[35:24] == $past(rsp_tdata[35:24]))))
      else $error("x moved within one column");
`endif

endmodule

`default_nettype wire

/* verif/sprite_tile_expander_tb.sv */
`timescale 1ns / 1ps

module sprite_tile_expander_tb;
   import ste_pkg::*;

   localparam int TILE_PX      = 16;
   localparam int TILES_SIDE   = 16;
   localparam int X_SHIFT      = 32;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 68;

   // index past the register list, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic        show;
      logic [15:0] size_word;
      logic [15:0] code_word;
      logic [15:0] x_word;
      logic [15:0] y_word;
      logic [15:0] color_word;
      logic [3:0]  column;
   } sprite_entry_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [COLOR_W-1:0] color;
      logic               mirror_x;
      logic               mirror_y;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic               last;
   } tile_cmd_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // screen setup as the block should hold it
   logic                  cfg_flip;
   logic [CSR_DATA_W-1:0] cfg_width;
   logic [CSR_DATA_W-1:0] cfg_height;

   tile_cmd_type expected_tiles[$];
   tile_cmd_type seen_tile;
   tile_cmd_type want_tile;
   int           mismatches;
   int           burst_left;
   logic         hold_request;

   sprite_tile_expander #(
      .TILE_PIXELS    (TILE_PX),
      .MAX_TILES_SIDE (TILES_SIDE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sprite_entry_type make_sprite(input logic show,
                                                    input logic [15:0] size_word,
                                                    input logic [15:0] code_word,
                                                    input logic [15:0] x_word,
                                                    input logic [15:0] y_word,
                                                    input logic [15:0] color_word,
                                                    input logic [3:0] column);
      sprite_entry_type s;
      s = '{show, size_word, code_word, x_word, y_word, color_word, column};
      return s;
   endfunction

   // queues the tile commands one sprite column should produce
   function automatic void expand_sprite(input sprite_entry_type s);
      tile_cmd_type cmd;
      int          dimx;
      int          dimy;
      int          col;
      int          row;
      int          sx;
      int          sy;
      logic [31:0] code;
      logic [31:0] base;
      logic [31:0] tile_no;
      logic [31:0] px;
      logic [31:0] py;
      logic        fx;
      logic        fy;
      if (!s.show) return;
      dimx = int'(s.size_word[3:0]) + 1;
      dimy = int'(s.size_word[7:4]) + 1;
      col = int'(s.column);
      if (col >= dimx) return;
      sx = $signed(s.x_word[9:0]);
      sy = $signed(s.y_word[9:0]);
      code = {16'd0, s.code_word};
      fx = s.size_word[12];
      fy = 1'b0;
      if (cfg_flip) begin
         sx = int'(cfg_width) - sx - dimx * TILE_PX - X_SHIFT;
         sy = int'(cfg_height) - sy - dimy * TILE_PX;
         fx = ~fx;
         fy = 1'b1;
         code = code + dimx * dimy - 1;
      end else begin
         sx = sx + X_SHIFT;
      end
      // carry out of bit 14 is dropped, the size word supplies bit 15
      base = {17'd0, code[14:0]} + {16'd0, s.size_word[8], 15'd0};
      for (row = 0; row < dimy; row++) begin
         tile_no = cfg_flip ? base - (col * dimy + row) : base + (col * dimy + row);
         px = sx + col * TILE_PX;
         py = sy + row * TILE_PX;
         cmd.code = tile_no[15:0];
         cmd.color = s.color_word[5:0];
         cmd.mirror_x = fx;
         cmd.mirror_y = fy;
         cmd.pos_x = px[11:0];
         cmd.pos_y = py[11:0];
         cmd.last = (row == dimy - 1);
         expected_tiles.push_back(cmd);
      end
   endfunction

   function automatic sprite_entry_type random_sprite();
      sprite_entry_type s;
      s.show = ($urandom_range(0, 9) != 0);
      s.size_word = 16'($urandom);
      s.code_word = 16'($urandom);
      s.x_word = 16'($urandom);
      s.y_word = 16'($urandom);
      s.color_word = 16'($urandom);
      // mostly short columns, any height up to the full one now and then
      if ($urandom_range(0, 3) != 0) s.size_word[7:4] = 4'($urandom_range(0, 3));
      if ($urandom_range(0, 7) != 0) s.column = 4'($urandom_range(0, s.size_word[3:0]));
      else s.column = 4'($urandom_range(0, 15));
      return s;
   endfunction

   function automatic string tile_text(input tile_cmd_type t);
      return $sformatf("code %h color %h mx %b my %b x %h y %h last %b",
                       t.code, t.color, t.mirror_x, t.mirror_y, t.pos_x, t.pos_y, t.last);
   endfunction

   // called and returns at a falling edge
   task automatic offer_sprite(input sprite_entry_type s);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tdata = {4'd0, s.column, s.color_word, s.y_word, s.x_word, s.code_word, s.size_word};
      req_tuser = s.show;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expand_sprite(s);
      burst_left--;
      @(negedge clock);
   endtask

   // hidden sprites give nothing, so let the block finish after the last tile
   task automatic wait_idle();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (expected_tiles.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_SCREEN_FLIP:   cfg_flip = value[0];
         CSR_SCREEN_WIDTH:  cfg_width = value;
         CSR_SCREEN_HEIGHT: cfg_height = value;
         default: ;
      endcase
   endtask

   task automatic set_screen(input logic flip, input int width, input int height);
      wait_idle();
      write_csr(CSR_SCREEN_FLIP, {9'($urandom), flip});
      write_csr(CSR_SCREEN_WIDTH, CSR_DATA_W'(width));
      write_csr(CSR_SCREEN_HEIGHT, CSR_DATA_W'(height));
   endtask

   task automatic test_default_screen();
      offer_sprite(make_sprite(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0));
      offer_sprite(make_sprite(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0));
      offer_sprite(make_sprite(1'b1, 16'h0003, 16'h1234, 16'h0010, 16'h0020, 16'h0005, 4'd4));
      offer_sprite(make_sprite(1'b1, 16'h01ff, 16'h7fff, 16'h01ff, 16'h01ff, 16'h003f, 4'd15));
      offer_sprite(make_sprite(1'b1, 16'h10f0, 16'h8000, 16'h0200, 16'h03ff, 16'hffc0, 4'd0));
      offer_sprite(make_sprite(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'd15));
      offer_sprite(make_sprite(1'b1, 16'h0e0f, 16'h00aa, 16'hfc00, 16'h7e00, 16'h0015, 4'd0));
      offer_sprite(make_sprite(1'b1, 16'h6a35, 16'h5555, 16'h8155, 16'h42aa, 16'haaaa, 4'd5));
      // write to the spare index must leave the screen setup alone
      wait_idle();
      write_csr(CSR_SPARE, '1);
      offer_sprite(make_sprite(1'b1, 16'h0021, 16'h0100, 16'h0050, 16'h0060, 16'h0011, 4'd1));
   endtask

   task automatic test_flipped_screen();
      set_screen(1'b1, 512, 512);
      offer_sprite(make_sprite(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0));
      offer_sprite(make_sprite(1'b1, 16'h00ff, 16'h0000, 16'h0100, 16'h0100, 16'h0001, 4'd0));
      offer_sprite(make_sprite(1'b1, 16'h00ff, 16'h0000, 16'h0100, 16'h0100, 16'h0001, 4'd15));
      offer_sprite(make_sprite(1'b1, 16'h00ff, 16'hffff, 16'h01ff, 16'h0200, 16'h0022, 4'd15));
      offer_sprite(make_sprite(1'b1, 16'h1132, 16'h7fff, 16'h0200, 16'h01ff, 16'h003f, 4'd2));
      offer_sprite(make_sprite(1'b0, 16'h00ff, 16'h0123, 16'h0000, 16'h0000, 16'h0000, 4'd3));
      offer_sprite(make_sprite(1'b1, 16'h0031, 16'h0456, 16'h0000, 16'h0000, 16'h0000, 4'd9));
      set_screen(1'b1, 1, 1);
      offer_sprite(make_sprite(1'b1, 16'h00ff, 16'h0800, 16'h01ff, 16'h01ff, 16'h0030, 4'd15));
      offer_sprite(make_sprite(1'b1, 16'h10ff, 16'h8001, 16'h0200, 16'h0200, 16'h000c, 4'd0));
   endtask

   task automatic test_random_screen(input logic flip, input int width, input int height);
      set_screen(flip, width, height);
      repeat (RANDOM_ITEMS) offer_sprite(random_sprite());
   endtask

   // output held off while tall columns keep coming, so the input has to stall
   task automatic test_output_backpressure();
      sprite_entry_type s;
      wait_idle();
      hold_request = 1'b1;
      repeat (20) begin
         s = random_sprite();
         s.show = 1'b1;
         s.size_word[7:4] = 4'hf;
         s.column = 4'($urandom_range(0, s.size_word[3:0]));
         offer_sprite(s);
      end
   endtask

   // receiver: random ready patterns in turn, plus a long hold on request
   initial begin
      int rsp_mode;
      int mode_cycles;
      int hold_cycles;
      rsp_tready = 1'b0;
      rsp_mode = 0;
      mode_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) @(negedge clock);
            hold_request = 1'b0;
         end
         if (mode_cycles == 0) begin
            rsp_mode = $urandom_range(0, 3);
            mode_cycles = $urandom_range(20, 80);
         end
         mode_cycles--;
         case (rsp_mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = 1'($urandom_range(0, 1));
            2: rsp_tready = ($urandom_range(0, 3) == 0);
            default: rsp_tready = ((mode_cycles % 5) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_tile = {rsp_tdata[15:0], rsp_tdata[21:16], rsp_tdata[22], rsp_tdata[23],
                      rsp_tdata[35:24], rsp_tdata[47:36], rsp_tlast};
         if (expected_tiles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: %s", tile_text(seen_tile));
         end else begin
            want_tile = expected_tiles.pop_front();
            if (seen_tile.code !== want_tile.code || seen_tile.color !== want_tile.color ||
                seen_tile.mirror_x !== want_tile.mirror_x ||
                seen_tile.mirror_y !== want_tile.mirror_y ||
                seen_tile.pos_x !== want_tile.pos_x || seen_tile.pos_y !== want_tile.pos_y ||
                seen_tile.last !== want_tile.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("tile mismatch at %0t", $realtime);
                  $display("  expected %s", tile_text(want_tile));
                  $display("  actual   %s", tile_text(seen_tile));
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake or register write
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_flip = 1'b0;
      cfg_width = SCREEN_WIDTH_RST;
      cfg_height = SCREEN_HEIGHT_RST;
      mismatches = 0;
      burst_left = 0;
      hold_request = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_default_screen();
      test_flipped_screen();
      test_random_screen(1'b0, 320, 224);
      test_random_screen(1'b1, 1, 1);
      test_random_screen(1'b0, 1, 512);
      test_random_screen(1'b1, 512, 512);
      test_random_screen(1'b1, $urandom_range(1, 512), $urandom_range(1, 512));
      test_output_backpressure();
      wait_idle();

      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* filelist.f */
design/ste_pkg.sv
design/ste_ctrl.sv
design/ste_datapath.sv
design/sprite_tile_expander.sv
verif/sprite_tile_expander_tb.sv
